/* rtl/altok_pkg.sv */
`timescale 1ns / 1ps
package altok_pkg;

  localparam int unsigned PosBits = 16;
  localparam int unsigned LenBits = 16;
  localparam logic [LenBits-1:0] LenMax = '1;

  typedef enum logic [2:0] {
    KindUnknown   = 3'd0,
    KindMnemonic  = 3'd1,
    KindOperand   = 3'd2,
    KindLabel     = 3'd3,
    KindDirective = 3'd4,
    KindSeparator = 3'd5,
    KindComment   = 3'd6,
    KindEol       = 3'd7
  } kind_e;

  localparam logic [7:0] CharColon     = 8'h3A;
  localparam logic [7:0] CharComma     = 8'h2C;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharSemicolon = 8'h3B;
  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharNine      = 8'h39;

  localparam int unsigned NumWords = 8;
  localparam logic [23:0] WordTable [NumWords] = '{
    24'h4A4D50, // JMP
    24'h4A5250, // JRP
    24'h4C444E, // LDN
    24'h53544F, // STO
    24'h535542, // SUB
    24'h43504D, // CPM
    24'h535450, // STP
    24'h564152  // VAR
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    kind_e               token_kind;
    logic [15:0]         token_start;
    logic [LenBits-1:0]  token_length;
    logic                last_of_run;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } step_res_t;

  // mnemonic, directive or unknown for a three-character word
  function automatic kind_e word_kind(input logic [23:0] word);
    kind_e k;
    k = KindUnknown;
    for (int i = 0; i < NumWords; i++) begin
      if (word == WordTable[i]) begin
        k = (i == NumWords - 1) ? KindDirective : KindMnemonic;
      end
    end
    return k;
  endfunction

endpackage

/* rtl/altok_step.sv */
`timescale 1ns / 1ps
module altok_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  altok_pkg::item_t   item_i,
  output altok_pkg::step_res_t res_o
);
  import altok_pkg::*;

  logic [PosBits-1:0] pos_q, pos_d;
  logic [PosBits-1:0] pstart_q, pstart_d;
  logic [LenBits-1:0] plen_q, plen_d;
  kind_e              pkind_q, pkind_d;
  logic               lbl_q, lbl_d;
  logic               cmt_q, cmt_d;
  logic               acmd_q, acmd_d;
  logic [7:0]         fc0_q, fc0_d;
  logic [7:0]         fc1_q, fc1_d;

  token_t     toks [2];
  logic [1:0] n;
  logic [7:0] c;
  logic       has_p;
  kind_e      wk;

  always_comb begin
    c       = item_i.char_code;
    has_p   = (plen_q != '0);
    pos_d   = pos_q + 1'b1;
    pstart_d = pstart_q;
    plen_d  = plen_q;
    pkind_d = pkind_q;
    lbl_d   = lbl_q;
    cmt_d   = cmt_q;
    acmd_d  = acmd_q;
    fc0_d   = fc0_q;
    fc1_d   = fc1_q;
    toks[0] = '0;
    toks[1] = '0;
    n       = 2'd0;
    wk      = word_kind({fc0_q, fc1_q, c});

    if (lbl_q && c == CharColon) begin
      if (has_p) begin
        toks[n[0]] = '{KindLabel, 16'(pstart_q), plen_q, 1'b0};
        n = n + 2'd1;
        plen_d  = '0;
        pkind_d = KindUnknown;
      end
      lbl_d = 1'b0;
    end else if (c == CharComma && !cmt_q) begin
      if (has_p) begin
        toks[n[0]] = '{pkind_q, 16'(pstart_q), plen_q, 1'b0};
        n = n + 2'd1;
      end
      plen_d = '0;
      toks[n[0]] = '{KindSeparator, 16'(pos_q), LenBits'(1), 1'b0};
      n = n + 2'd1;
      pkind_d = KindUnknown;
    end else if ((c == CharSpace || c == CharTab) && !cmt_q) begin
      if (has_p) begin
        toks[n[0]] = '{pkind_q, 16'(pstart_q), plen_q, 1'b0};
        n = n + 2'd1;
        plen_d  = '0;
        pkind_d = KindUnknown;
      end
    end else if (c == CharSemicolon) begin
      cmt_d = 1'b1;
      if (has_p) begin
        toks[n[0]] = '{pkind_q, 16'(pstart_q), plen_q, 1'b0};
        n = n + 2'd1;
      end
      plen_d  = '0;
      pkind_d = KindComment;
    end else if (c == CharNewline) begin
      if (cmt_q) begin
        toks[n[0]] = '{KindComment, has_p ? 16'(pstart_q) : 16'(pos_q), plen_q, 1'b0};
        n = n + 2'd1;
      end else if (has_p) begin
        toks[n[0]] = '{pkind_q, 16'(pstart_q), plen_q, 1'b0};
        n = n + 2'd1;
      end
      plen_d = '0;
      lbl_d  = 1'b1;
      cmt_d  = 1'b0;
      toks[n[0]] = '{KindEol, 16'(pos_q), LenBits'(1), 1'b0};
      n = n + 2'd1;
      pkind_d = KindUnknown;
    end else begin
      // append, spaces and tabs inside a comment included
      if (plen_q == '0) begin
        pstart_d = pos_q;
        fc0_d    = c;
      end
      if (plen_q == LenBits'(1)) begin
        fc1_d = c;
      end
      if (plen_q != LenMax) begin
        plen_d = plen_q + 1'b1;
      end
      if (pkind_q == KindUnknown && !((c == CharSpace || c == CharTab))) begin
        if (plen_d == LenBits'(1) && c >= CharZero && c <= CharNine) begin
          pkind_d = KindOperand;
        end else if (acmd_q) begin
          acmd_d  = 1'b0;
          pkind_d = KindOperand;
        end else if (plen_d == LenBits'(3) && wk != KindUnknown) begin
          acmd_d  = 1'b1;
          pkind_d = wk;
        end
      end
    end

    if (item_i.end_of_text) begin
      if (plen_d != '0) begin
        toks[n[0]] = '{pkind_d, 16'(pstart_d), plen_d, 1'b0};
        n = n + 2'd1;
      end
      pos_d    = '0;
      pstart_d = '0;
      plen_d   = '0;
      pkind_d  = KindUnknown;
      lbl_d    = 1'b1;
      cmt_d    = 1'b0;
      acmd_d   = 1'b0;
      fc0_d    = '0;
      fc1_d    = '0;
    end

    if (n == 2'd1) begin
      toks[0].last_of_run = 1'b1;
    end
    if (n == 2'd2) begin
      toks[1].last_of_run = 1'b1;
    end

    res_o.count = n;
    res_o.tok0  = toks[0];
    res_o.tok1  = toks[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      pstart_q <= '0;
      plen_q   <= '0;
      pkind_q  <= KindUnknown;
      lbl_q    <= 1'b1;
      cmt_q    <= 1'b0;
      acmd_q   <= 1'b0;
      fc0_q    <= '0;
      fc1_q    <= '0;
    end else if (en_i) begin
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      pkind_q  <= pkind_d;
      lbl_q    <= lbl_d;
      cmt_q    <= cmt_d;
      acmd_q   <= acmd_d;
      fc0_q    <= fc0_d;
      fc1_q    <= fc1_d;
    end
  end

endmodule

/* rtl/altok_outq.sv */
`timescale 1ns / 1ps
module altok_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  altok_pkg::step_res_t res_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output altok_pkg::token_t    out_item_o,
  output logic [1:0]           count_o
);
  import altok_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  token_t     head_q, head_d;
  token_t     tail_q, tail_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = head_q;
  assign count_o     = cnt_q;
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    tail_d = tail_q;
    if (load_i) begin
      cnt_d  = res_i.count;
      head_d = res_i.tok0;
      tail_d = res_i.tok1;
    end else if (pop) begin
      if (cnt_q == 2'd2) begin
        head_d = tail_q;
        cnt_d  = 2'd1;
      end else begin
        cnt_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

/* rtl/assembly_line_tokenizer_top.sv */
`timescale 1ns / 1ps
// Assembly line tokenizer: one source character per item in, token descriptors
// (kind, start, length, last_of_run) out. A character waits in the input
// register until it is consumed, and its tokens are then loaded into the
// output register, from which the first token is offered. One character is
// taken every cycle while each character gives at most one token and the
// output is not stalled; a character that gives two (comma or newline ending
// a pending token, or newline closing a comment) holds the input side while
// the two-entry output buffer drains.
// Positions wrap at the position width and lengths saturate at 65535.
module assembly_line_tokenizer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  altok_pkg::item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output altok_pkg::token_t out_item_o
);
  import altok_pkg::*;

  item_t     item_q;
  logic      valid_q;
  logic      consume;
  logic [1:0] out_cnt;
  step_res_t res;

  assign consume    = valid_q &&
                      (out_cnt == 2'd0 || (out_cnt == 2'd1 && !out_stall_i));
  assign in_stall_o = valid_q && !consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

  altok_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (consume),
    .item_i (item_q),
    .res_o  (res)
  );

  altok_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (consume),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .count_o     (out_cnt)
  );

endmodule

/* dv/assembly_line_tokenizer_top_test.sv */
`timescale 1ns / 1ps
module assembly_line_tokenizer_top_test;
  import altok_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned IdlePct = 25;
  localparam logic [23:0] OpWords [7] = '{"JMP", "JRP", "LDN", "STO", "SUB", "CPM", "STP"};
  localparam logic [23:0] DirWord = "VAR";

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid = 1'b0;
  item_t  in_item = '0;
  logic   in_stall;
  logic   out_valid;
  logic   out_stall = 1'b0;
  token_t out_item;

  item_t  source_chars [$];
  token_t expected_tokens [$];

  // tokenizer state as predicted
  logic [15:0] pos_q;
  logic [15:0] pend_start;
  logic [15:0] pend_len;
  kind_e       pend_kind;
  logic        label_pos;
  logic        in_comment;
  logic        after_cmd;
  logic [7:0]  head_chars [3];
  token_t      run_toks [2];
  int          run_n;

  int          faults = 0;
  int          tokens_seen = 0;
  int          chars_queued = 0;
  int unsigned cycle_count = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm = 1'b0;
  logic        eot_mix = 1'b0;

  assembly_line_tokenizer_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #1 clk_i = ~clk_i;

  task automatic restart_text();
    pos_q = '0;
    pend_start = '0;
    pend_len = '0;
    pend_kind = KindUnknown;
    label_pos = 1'b1;
    in_comment = 1'b0;
    after_cmd = 1'b0;
    for (int i = 0; i < 3; i++) head_chars[i] = 8'h00;
  endtask

  task automatic note_token(input kind_e k, input logic [15:0] s, input logic [15:0] l);
    if (run_n < 2) begin
      run_toks[run_n].token_kind = k;
      run_toks[run_n].token_start = s;
      run_toks[run_n].token_length = l;
      run_toks[run_n].last_of_run = 1'b0;
      run_n++;
    end
  endtask

  task automatic flush_word();
    if (pend_len != 0) note_token(pend_kind, pend_start, pend_len);
    pend_len = '0;
  endtask

  task automatic append_char(input logic [7:0] c);
    if (pend_len == 0) pend_start = pos_q;
    if (pend_len < 3) head_chars[pend_len[1:0]] = c;
    if (pend_len != LenMax) pend_len = pend_len + 16'd1;
  endtask

  task automatic settle_kind();
    logic [23:0] head;
    head = {head_chars[0], head_chars[1], head_chars[2]};
    if (pend_len == 1 && head_chars[0] >= CharZero && head_chars[0] <= CharNine) begin
      pend_kind = KindOperand;
    end else if (after_cmd) begin
      after_cmd = 1'b0;
      pend_kind = KindOperand;
    end else if (pend_len == 3) begin
      if (head == DirWord) begin
        after_cmd = 1'b1;
        pend_kind = KindDirective;
      end
      for (int i = 0; i < 7; i++) begin
        if (head == OpWords[i]) begin
          after_cmd = 1'b1;
          pend_kind = KindMnemonic;
        end
      end
    end
  endtask

  task automatic tokenize_char(input item_t it);
    logic [7:0] c;
    c = it.char_code;
    run_n = 0;
    if (label_pos && c == CharColon) begin
      if (pend_len != 0) begin
        note_token(KindLabel, pend_start, pend_len);
        pend_len = '0;
        pend_kind = KindUnknown;
      end
      label_pos = 1'b0;
    end else if (c == CharComma && !in_comment) begin
      flush_word();
      note_token(KindSeparator, pos_q, 16'd1);
      pend_kind = KindUnknown;
    end else if (c == CharSpace || c == CharTab) begin
      if (!in_comment) begin
        if (pend_len != 0) begin
          flush_word();
          pend_kind = KindUnknown;
        end
      end else begin
        append_char(c);
      end
    end else if (c == CharSemicolon) begin
      in_comment = 1'b1;
      flush_word();
      pend_kind = KindComment;
    end else if (c == CharNewline) begin
      if (in_comment) note_token(KindComment, (pend_len != 0) ? pend_start : pos_q, pend_len);
      else flush_word();
      pend_len = '0;
      label_pos = 1'b1;
      in_comment = 1'b0;
      note_token(KindEol, pos_q, 16'd1);
      pend_kind = KindUnknown;
    end else begin
      append_char(c);
      if (pend_kind == KindUnknown) settle_kind();
    end
    pos_q = pos_q + 16'd1;
    if (it.end_of_text) begin
      flush_word();
      restart_text();
    end
    if (run_n > 0) run_toks[run_n-1].last_of_run = 1'b1;
    for (int i = 0; i < run_n; i++) expected_tokens = {expected_tokens, run_toks[i]};
  endtask

  task automatic check_token(input token_t got);
    token_t want;
    tokens_seen++;
    if (expected_tokens.size() == 0) begin
      faults++;
      if (faults <= 10) begin
        $display("unexpected token: kind %0d start %0d len %0d last %0b",
                 got.token_kind, got.token_start, got.token_length, got.last_of_run);
      end
    end else begin
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind || got.token_start !== want.token_start ||
          got.token_length !== want.token_length || got.last_of_run !== want.last_of_run) begin
        faults++;
        if (faults <= 10) begin
          $display("token %0d: expected kind %0d start %0d len %0d last %0b", tokens_seen,
                   want.token_kind, want.token_start, want.token_length, want.last_of_run);
          $display("token %0d: got      kind %0d start %0d len %0d last %0b", tokens_seen,
                   got.token_kind, got.token_start, got.token_length, got.last_of_run);
        end
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) tokenize_char(in_item);
      if (!in_valid || !in_stall) begin
        if (source_chars.size() != 0 &&
            (calm || hold_left != 0 || $urandom_range(99) >= IdlePct)) begin
          in_valid <= 1'b1;
          in_item <= source_chars.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor; one long hold-off once the stream is well under way
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_token(out_item);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && tokens_seen >= 200) begin
        hold_done <= 1'b1;
        hold_left <= 300;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic put(input logic [7:0] c, input logic eot = 1'b0);
    item_t it;
    it.char_code = c;
    it.end_of_text = eot || (eot_mix && $urandom_range(59) == 0);
    source_chars = {source_chars, it};
    chars_queued++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_word3(input logic [23:0] w);
    put(w[23:16]);
    put(w[15:8]);
    put(w[7:0]);
  endtask

  task automatic put_gap();
    repeat ($urandom_range(1, 2)) put($urandom_range(1) ? CharSpace : CharTab);
  endtask

  task automatic put_word();
    int n;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(i == 0 ? 3 : 4) == 0) put(8'(CharZero + $urandom_range(9)));
      else put(8'(8'h41 + $urandom_range(25) + ($urandom_range(1) ? 8'h20 : 8'h00)));
    end
  endtask

  task automatic queue_line();
    logic [23:0] w;
    int k;
    int j;
    if ($urandom_range(2) == 0) begin
      put_word();
      put(CharColon);
    end
    if ($urandom_range(1) == 0) put_gap();
    k = $urandom_range(9);
    if (k < 7) begin
      put_word3(OpWords[k]);
    end else if (k == 7) begin
      put_word3(DirWord);
    end else if (k == 8) begin
      w = OpWords[$urandom_range(6)];
      j = $urandom_range(2);
      w[8*j +: 8] = 8'(8'h41 + $urandom_range(25));
      put_word3(w);
    end else begin
      put_word();
    end
    k = $urandom_range(3);
    for (int i = 0; i < k; i++) begin
      if (i == 0 || $urandom_range(1) == 0) put_gap();
      else put(CharComma);
      put_word();
    end
    if ($urandom_range(5) == 0) put($urandom_range(1) ? CharComma : CharSpace);
    if ($urandom_range(2) == 0) begin
      if ($urandom_range(1) == 0) put_gap();
      put(CharSemicolon);
      repeat ($urandom_range(8)) begin
        case ($urandom_range(9))
          0: put(CharSpace);
          1: put(CharTab);
          2: put(CharComma);
          3: put(CharColon);
          4: put(CharSemicolon);
          default: put(8'(8'h61 + $urandom_range(25)));
        endcase
      end
    end
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 4)) put(8'($urandom_range(255)));
    put(CharNewline);
  endtask

  task automatic wait_for_tokens();
    while (source_chars.size() != 0 || in_valid || expected_tokens.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    int base;
    restart_text();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    put_text("x:JMP y,z\n");
    // space inside comment, colon closing it as a label, then empty comment
    put_text("; :\n");
    put(8'h00);
    put(8'hFF, 1'b1);
    put_text("VAR 5");
    put(CharColon, 1'b1);
    put(CharSemicolon);
    put("c", 1'b1);
    put(CharSemicolon, 1'b1);
    wait_for_tokens();

    eot_mix = 1'b1;
    base = chars_queued;
    while (chars_queued < base + 500) queue_line();
    while (source_chars.size() != 0) @(posedge clk_i);
    calm = 1'b1;
    while (chars_queued < base + 850) queue_line();
    while (source_chars.size() != 0) @(posedge clk_i);
    calm = 1'b0;
    while (chars_queued < base + 1450) queue_line();
    eot_mix = 1'b0;

    wait_for_tokens();
    repeat (20) @(posedge clk_i);
    if (faults == 0 && expected_tokens.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/altok_pkg.sv
rtl/altok_step.sv
rtl/altok_outq.sv
rtl/assembly_line_tokenizer_top.sv
dv/assembly_line_tokenizer_top_test.sv
